// ===== rtl/vector_terminal_stream_decoder_core_assert.svh =====
// Assertion macros shared by the stream decoder modules.
// Depends on nothing; included inside module bodies after the logic.
`ifndef VECTOR_TERMINAL_STREAM_DECODER_CORE_ASSERT_SVH
`define VECTOR_TERMINAL_STREAM_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTSD_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vtsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VTSD_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vtsd assertion failed");

`endif

// ===== rtl/vtsd_pkg.sv =====
// Shared types and codes for the vector-terminal stream decoder.
// Depends on nothing; imported by all modules and the testbench.
package vtsd_pkg;

  // Result command codes.
  typedef enum logic [3:0] {
    CMD_MOVE      = 4'd0,
    CMD_DRAW      = 4'd1,
    CMD_TEXT_CHAR = 4'd2,
    CMD_TEXT_END  = 4'd3,
    CMD_ERASE     = 4'd4,
    CMD_FONT      = 4'd5,
    CMD_STYLE     = 4'd6,
    CMD_FILL      = 4'd7,
    CMD_UNKNOWN   = 4'd8
  } cmd_t;

  // Parser modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ALPHA  = 2'd1,
    MODE_ESC    = 2'd2,
    MODE_INCR   = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CHAR_ADVANCE = 2'd0,
    REG_SPACE_STEP   = 2'd1,
    REG_LINE_STEP    = 2'd2,
    REG_RETURN_STEP  = 2'd3
  } reg_idx_t;

  // Byte codes the parser treats specially.
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_FS  = 8'h1C;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_GS  = 8'h1D;
  localparam logic [7:0] CH_RS  = 8'h1E;
  localparam logic [7:0] CH_US  = 8'h1F;

  localparam int unsigned MAX_RESULTS = 3;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0] char_advance;
    logic [7:0] space_step;
    logic [7:0] line_step;
    logic [7:0] return_step;
  } cfg_t;

  // One result without its last flag.
  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        argument;
    logic               pen_down;
  } res_t;

  // All results that one byte causes, in order from entry 0.
  typedef struct packed {
    logic [1:0] count;
    res_t [2:0] entry;
  } batch_t;

endpackage

// ===== rtl/vtsd_interfaces.sv =====
// Handshake channel interfaces for the stream decoder.
// Depends on vtsd_pkg for nothing but shared conventions; plain widths used.
interface vtsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface vtsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface vtsd_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        argument;
  logic               pen_down;
  logic               last;

  modport source (output valid, output command, output pos_x, output pos_y,
                  output argument, output pen_down, output last, input ready);
  modport sink (input valid, input command, input pos_x, input pos_y,
                input argument, input pen_down, input last, output ready);
endinterface

// ===== rtl/vector_terminal_stream_decoder_core.sv =====
// Top level of the vector-terminal stream decoder: configuration registers
// and channel wiring. Depends on vtsd_pkg, the interfaces, vtsd_decoder and
// vtsd_result_queue.
//
// One stream byte is accepted per cycle while the buffer can load it. The
// byte is decoded in the same cycle it is accepted, and its zero to three
// results are loaded together into a three-entry result buffer that sends
// one result per cycle while results are ready. A one-result byte lets the
// next byte in on the next cycle if that result is taken then; a byte with
// two or three results holds the stream while the buffer drains. Stream
// ready follows result ready combinationally when one result is left.
// Configuration writes are always ready and take effect on the next byte.
module vector_terminal_stream_decoder_core #(
  parameter int COORD_BITS    = 10,
  parameter int TEXT_POS_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  vtsd_byte_if.sink     stream,
  vtsd_cfg_if.sink      cfg,
  vtsd_result_if.source results
);
  import vtsd_pkg::*;

  cfg_t   cfg_regs;
  batch_t batch;
  res_t   head;
  logic   can_load;
  logic   accept;

  // Configuration register file.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.char_advance <= 8'd12;
      cfg_regs.space_step   <= 8'd10;
      cfg_regs.line_step    <= 8'd17;
      cfg_regs.return_step  <= 8'd10;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_CHAR_ADVANCE: cfg_regs.char_advance <= cfg.data;
        REG_SPACE_STEP:   cfg_regs.space_step   <= cfg.data;
        REG_LINE_STEP:    cfg_regs.line_step    <= cfg.data;
        REG_RETURN_STEP:  cfg_regs.return_step  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign stream.ready = can_load;
  assign accept       = stream.valid && can_load;

  vtsd_decoder #(
    .COORD_BITS    (COORD_BITS),
    .TEXT_POS_BITS (TEXT_POS_BITS)
  ) u_decoder (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream.stream_byte),
    .cfg         (cfg_regs),
    .batch       (batch)
  );

  vtsd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_entry (head),
    .out_last  (results.last)
  );

  // Result payload.
  assign results.command  = head.command;
  assign results.pos_x    = head.pos_x;
  assign results.pos_y    = head.pos_y;
  assign results.argument = head.argument;
  assign results.pen_down = head.pen_down;

endmodule

// ===== rtl/vtsd_decoder.sv =====
// Parser state registers and the single-pass byte decoder.
// Depends on vtsd_pkg and the assertion macro header.
module vtsd_decoder #(
  parameter int COORD_BITS    = 10,
  parameter int TEXT_POS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        stream_byte,
  input  vtsd_pkg::cfg_t    cfg,
  output vtsd_pkg::batch_t  batch
);
  import vtsd_pkg::*;

  // Working width for text arithmetic and saturation.
  localparam int SW = ((TEXT_POS_BITS > 16) ? TEXT_POS_BITS : 16) + 2;
  localparam int TP = TEXT_POS_BITS;
  localparam int CB = COORD_BITS;
  localparam logic signed [SW-1:0] TEXT_MAX = {{(SW-TP+1){1'b0}}, {(TP-1){1'b1}}};
  localparam logic signed [SW-1:0] TEXT_MIN = ~TEXT_MAX;
  localparam logic signed [SW-1:0] OUT_MAX  = {{(SW-15){1'b0}}, {15{1'b1}}};
  localparam logic signed [SW-1:0] OUT_MIN  = ~OUT_MAX;
  localparam logic signed [SW-1:0] COORD_MAX = {{(SW-CB){1'b0}}, {CB{1'b1}}};

  mode_t                  mode, mode_next;
  logic [1:0]             addr_phase, addr_phase_next;
  logic [CB-1:0]          beam_x, beam_x_next, beam_y, beam_y_next;
  logic signed [TP-1:0]   text_x, text_x_next, text_y, text_y_next;
  logic                   draw_cont, draw_cont_next;
  logic                   dots_on, dots_on_next;
  logic signed [15:0]     step_x, step_x_next, step_y, step_y_next;
  logic [15:0]            label_len, label_len_next;

  // Saturate a working value to the text position range.
  function automatic logic signed [TP-1:0] sat_text(input logic signed [SW-1:0] v);
    logic signed [TP-1:0] r;
    if (v > TEXT_MAX) r = TEXT_MAX[TP-1:0];
    else if (v < TEXT_MIN) r = TEXT_MIN[TP-1:0];
    else r = v[TP-1:0];
    return r;
  endfunction

  // Saturate a working value to the 16-bit output range.
  function automatic logic signed [15:0] sat_out(input logic signed [SW-1:0] v);
    logic signed [15:0] r;
    if (v > OUT_MAX) r = 16'sh7FFF;
    else if (v < OUT_MIN) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Step counter update by -1, 0 or +1 with 16-bit saturation.
  function automatic logic signed [15:0] step_add(input logic signed [15:0] s,
                                                  input logic signed [1:0] d);
    logic signed [16:0] sum;
    logic signed [15:0] r;
    sum = 17'(s) + 17'(d);
    if (sum[16] != sum[15]) r = sum[16] ? 16'sh8000 : 16'sh7FFF;
    else r = sum[15:0];
    return r;
  endfunction

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      beam_x    <= '0;
      beam_y    <= '0;
      text_x    <= '0;
      text_y    <= '0;
      draw_cont <= 1'b0;
      dots_on   <= 1'b1;
      step_x    <= '0;
      step_y    <= '0;
      label_len <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      beam_x    <= beam_x_next;
      beam_y    <= beam_y_next;
      text_x    <= text_x_next;
      text_y    <= text_y_next;
      draw_cont <= draw_cont_next;
      dots_on   <= dots_on_next;
      step_x    <= step_x_next;
      step_y    <= step_y_next;
      label_len <= label_len_next;
    end
  end

  // Decode one byte: next state and the results it causes.
  always_comb begin
    logic [7:0]            b;
    logic [1:0]            n;
    logic                  run_normal;
    logic signed [SW-1:0]  tx_ext, ty_ext, sum;
    logic signed [15:0]    tx_out, ty_out;
    logic signed [1:0]     dx, dy;
    logic [CB-1:0]         bx, by;

    b          = stream_byte;
    n          = 2'd0;
    run_normal = 1'b0;
    dx         = 2'sd0;
    dy         = 2'sd0;
    bx         = '0;
    by         = '0;
    sum        = '0;
    tx_ext     = SW'(text_x);
    ty_ext     = SW'(text_y);
    tx_out     = sat_out(tx_ext);
    ty_out     = sat_out(ty_ext);
    batch      = '0;

    mode_next       = mode;
    addr_phase_next = addr_phase;
    beam_x_next     = beam_x;
    beam_y_next     = beam_y;
    text_x_next     = text_x;
    text_y_next     = text_y;
    draw_cont_next  = draw_cont;
    dots_on_next    = dots_on;
    step_x_next     = step_x;
    step_y_next     = step_y;
    label_len_next  = label_len;

    case (mode)
      MODE_ALPHA: begin
        if (b[7] == 1'b0 && b[6:5] != 2'b00) begin
          // Label character; the first one is preceded by a move.
          if (label_len == 16'd0) begin
            batch.entry[n] = '{CMD_MOVE, tx_out, ty_out, 15'd0, dots_on};
            n = n + 2'd1;
          end
          batch.entry[n] = '{CMD_TEXT_CHAR, tx_out, ty_out, 15'(b), dots_on};
          n = n + 2'd1;
          text_x_next = sat_text(tx_ext + SW'(cfg.char_advance));
          if (label_len != 16'hFFFF) label_len_next = label_len + 16'd1;
        end else begin
          // Run ends; the byte is then parsed as in normal mode.
          if (label_len != 16'd0) begin
            batch.entry[n] = '{CMD_TEXT_END, tx_out, ty_out,
                               (label_len > 16'h7FFF) ? 15'h7FFF : label_len[14:0],
                               dots_on};
            n = n + 2'd1;
            draw_cont_next = 1'b0;
          end
          label_len_next = '0;
          mode_next      = MODE_NORMAL;
          run_normal     = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_NORMAL;
        if (b == CH_FF) begin
          // Erase resets pen, beam, font and style.
          dots_on_next = 1'b1;
          beam_x_next  = '0;
          beam_y_next  = '0;
          batch.entry[0] = '{CMD_ERASE, 16'sd0, 16'sd0, 15'd0, 1'b1};
          batch.entry[1] = '{CMD_FONT, 16'sd0, 16'sd0, 15'd8, 1'b1};
          batch.entry[2] = '{CMD_STYLE, 16'sd0, 16'sd0, 15'd0, 1'b1};
          n = 2'd3;
        end else if (b >= 8'h30 && b <= 8'h33) begin
          batch.entry[0] = '{CMD_FONT, 16'sd0, 16'sd0,
                             15'(b[1:0]) * 15'd2 + 15'd8, dots_on};
          n = 2'd1;
        end else if (b == 8'h40) begin
          batch.entry[0] = '{CMD_FILL, 16'sd0, 16'sd0, 15'd1, dots_on};
          n = 2'd1;
        end else if (b >= 8'h41 && b <= 8'h47) begin
          batch.entry[0] = '{CMD_FILL, 16'sd0, 16'sd0, 15'h7FFF, dots_on};
          n = 2'd1;
        end else if (b >= 8'h60 && b <= 8'h64) begin
          batch.entry[0] = '{CMD_STYLE, 16'sd0, 16'sd0, 15'(b[2:0]), dots_on};
          n = 2'd1;
        end else if (b >= 8'h78 && b <= 8'h7A) begin
          batch.entry[0] = '{CMD_STYLE, 16'sd0, 16'sd0,
                             15'(b[2:0]) + 15'd5, dots_on};
          n = 2'd1;
        end
      end
      MODE_INCR: begin
        if (b == CH_US) begin
          // Leave incremental mode: apply steps to beam and text position.
          sum = SW'(beam_x) + SW'(step_x);
          if (sum < 0) bx = '0;
          else if (sum > COORD_MAX) bx = COORD_MAX[CB-1:0];
          else bx = sum[CB-1:0];
          sum = SW'(beam_y) + SW'(step_y);
          if (sum < 0) by = '0;
          else if (sum > COORD_MAX) by = COORD_MAX[CB-1:0];
          else by = sum[CB-1:0];
          beam_x_next = bx;
          beam_y_next = by;
          batch.entry[0] = '{CMD_MOVE, 16'(bx), 16'(by), 15'd0, dots_on};
          n = 2'd1;
          sum = tx_ext + SW'(step_x);
          if (sum < 0) text_x_next = '0;
          else if (sum > TEXT_MAX) text_x_next = TEXT_MAX[TP-1:0];
          else text_x_next = sum[TP-1:0];
          sum = ty_ext + SW'(step_y);
          if (sum < 0) text_y_next = '0;
          else if (sum > TEXT_MAX) text_y_next = TEXT_MAX[TP-1:0];
          else text_y_next = sum[TP-1:0];
          mode_next  = MODE_NORMAL;
          run_normal = 1'b1;
        end else begin
          case (b)
            8'h20: dots_on_next = 1'b0;
            8'h50: dots_on_next = 1'b1;
            8'h41: dx = 2'sd1;
            8'h45: begin dx = 2'sd1;  dy = 2'sd1;  end
            8'h44: dy = 2'sd1;
            8'h46: begin dx = -2'sd1; dy = 2'sd1;  end
            8'h42: dx = -2'sd1;
            8'h4A: begin dx = -2'sd1; dy = -2'sd1; end
            8'h48: dy = -2'sd1;
            8'h49: begin dx = 2'sd1;  dy = -2'sd1; end
            default: ;
          endcase
          step_x_next = step_add(step_x, dx);
          step_y_next = step_add(step_y, dy);
        end
      end
      default: begin
        mode_next  = MODE_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    // Normal-mode parsing. Other modes pass only control codes and bytes
    // above 7F here, so address and text arithmetic read registered state.
    if (run_normal) begin
      if (b[7] == 1'b0 && b[6:5] != 2'b00) begin
        case (b[6:5])
          2'b01: begin
            // High byte: high-X right after low-Y, otherwise high-Y.
            if (addr_phase == 2'd2) begin
              beam_x_next     = CB'({b[4:0], beam_x[4:0]});
              addr_phase_next = 2'd3;
            end else begin
              beam_y_next     = CB'({b[4:0], beam_y[4:0]});
              addr_phase_next = 2'd1;
            end
          end
          2'b11: begin
            beam_y_next     = {beam_y[CB-1:5], b[4:0]};
            addr_phase_next = 2'd2;
          end
          default: begin
            // Low-X always completes the address.
            beam_x_next     = {beam_x[CB-1:5], b[4:0]};
            addr_phase_next = 2'd0;
            text_x_next     = sat_text(SW'(beam_x_next));
            text_y_next     = sat_text(SW'(beam_y));
            batch.entry[n]  = '{draw_cont ? CMD_DRAW : CMD_MOVE, 16'(beam_x_next),
                                16'(beam_y), 15'd0, dots_on};
            n = n + 2'd1;
            draw_cont_next = 1'b1;
          end
        endcase
      end else begin
        case (b)
          CH_NUL, CH_BEL, CH_CAN, CH_FS: ;
          CH_BS: text_x_next = sat_text(tx_ext - SW'(cfg.space_step));
          CH_HT: text_x_next = sat_text(tx_ext + SW'(cfg.space_step));
          CH_LF: text_y_next = sat_text(ty_ext - SW'(cfg.line_step));
          CH_VT: text_y_next = sat_text(ty_ext + SW'(cfg.line_step));
          CH_CR: begin
            text_y_next    = sat_text(ty_ext - SW'(cfg.return_step));
            text_x_next    = '0;
            dots_on_next   = 1'b1;
            mode_next      = MODE_ALPHA;
            label_len_next = '0;
          end
          CH_US: begin
            mode_next      = MODE_ALPHA;
            label_len_next = '0;
          end
          CH_ESC: mode_next = MODE_ESC;
          CH_GS: draw_cont_next = 1'b0;
          CH_RS: begin
            mode_next   = MODE_INCR;
            step_x_next = '0;
            step_y_next = '0;
          end
          default: begin
            batch.entry[n] = '{CMD_UNKNOWN, 16'sd0, 16'sd0, 15'(b), dots_on};
            n = n + 2'd1;
          end
        endcase
      end
    end

    batch.count = n;
  end

  // Address phase register; only normal-mode parsing changes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_phase <= 2'd0;
    end else if (accept) begin
      addr_phase <= addr_phase_next;
    end
  end

  `include "vector_terminal_stream_decoder_core_assert.svh"

  `VTSD_ASSERT_NEXT(a_esc_one_byte, clk, rst, accept && mode == MODE_ESC,
                    mode == MODE_NORMAL)
  `VTSD_ASSERT_SAME(a_label_char_gives_result, clk, rst,
                    mode == MODE_ALPHA && stream_byte[7] == 1'b0 &&
                    stream_byte[6:5] != 2'b00, batch.count != 2'd0)
  `VTSD_ASSERT_NEXT(a_state_holds_when_idle, clk, rst, !accept,
                    $stable(beam_x) && $stable(beam_y) && $stable(text_x))

endmodule

// ===== rtl/vtsd_result_queue.sv =====
// Three-entry result buffer that drains one result per cycle while results are taken.
// Depends on vtsd_pkg and the assertion macro header.
module vtsd_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  vtsd_pkg::batch_t  batch,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output vtsd_pkg::res_t    out_entry,
  output logic              out_last
);
  import vtsd_pkg::*;

  res_t [2:0] slot;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_entry = slot[0];
  // Batches load only into an empty or emptying buffer, so the final entry is last.
  assign out_last  = (count == 2'd1);
  assign can_load  = (count == 2'd0) || (count == 2'd1 && pop);

  // Count of waiting results.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load && batch.count != 2'd0) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // Result slots: load a whole batch or shift toward the head.
  always_ff @(posedge clk) begin
    if (load && batch.count != 2'd0) begin
      slot <= batch.entry;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  `include "vector_terminal_stream_decoder_core_assert.svh"

  `VTSD_ASSERT_SAME(a_load_only_when_empty, clk, rst, load,
                    count == 2'd0 || (count == 2'd1 && pop))
  `VTSD_ASSERT_NEXT(a_pop_counts_down, clk, rst, pop && !load,
                    count == $past(count) - 2'd1)
  `VTSD_ASSERT_NEXT(a_batch_shows_up, clk, rst, load && batch.count != 2'd0,
                    out_valid && count == $past(batch.count))

endmodule

// ===== tb/sv/vector_terminal_stream_decoder_core_tb.sv =====
// Self-checking testbench for the vector-terminal stream decoder top level.
// Depends on vtsd_pkg, the channel interfaces and the RTL of the decoder core;
// a built-in behavioral predictor supplies the expected command stream.
module vector_terminal_stream_decoder_core_tb;
  import vtsd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int COORD_MAX   = 1023;
  localparam int TEXT_MAX    = 32767;
  localparam int TEXT_MIN    = -32768;

  // One expected result together with its last flag.
  typedef struct packed {
    res_t body;
    logic last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vtsd_byte_if   stream_ch ();
  vtsd_cfg_if    cfg_ch ();
  vtsd_result_if res_ch ();

  vector_terminal_stream_decoder_core DUT (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .cfg     (cfg_ch),
    .results (res_ch)
  );

  // Clock generation.
  always #5 clk = ~clk;

  // Bookkeeping.
  decoded_t pending_cmds[$];
  int       cycles;
  int       mismatches;
  int       bytes_sent;
  int       results_checked;
  int       reg_writes;
  int       gap_pct;
  int       stall_pct;
  int       stall_left;

  // Predictor state and its copy of the registers.
  cfg_t        regs;
  mode_t       mode;
  logic [1:0]  addr_phase;
  logic [9:0]  beam_x;
  logic [9:0]  beam_y;
  int          text_x;
  int          text_y;
  logic        draw_cont;
  logic        dots_on;
  int          step_x;
  int          step_y;
  int          label_len;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void reset_predictor();
    regs.char_advance = 8'd12;
    regs.space_step   = 8'd10;
    regs.line_step    = 8'd17;
    regs.return_step  = 8'd10;
    mode       = MODE_NORMAL;
    addr_phase = 2'd0;
    beam_x     = '0;
    beam_y     = '0;
    text_x     = 0;
    text_y     = 0;
    draw_cont  = 1'b0;
    dots_on    = 1'b1;
    step_x     = 0;
    step_y     = 0;
    label_len  = 0;
  endfunction

  // Queue one expected command; pen state is taken as it stands now.
  function automatic void push_cmd(input cmd_t c, input int x, input int y, input int arg);
    decoded_t d;
    d.body.command  = c;
    d.body.pos_x    = 16'(clamp_int(x, -32768, 32767));
    d.body.pos_y    = 16'(clamp_int(y, -32768, 32767));
    d.body.argument = 15'(arg);
    d.body.pen_down = dots_on;
    d.last          = 1'b0;
    pending_cmds.push_back(d);
  endfunction

  // Address bytes: high bytes go to Y unless a low-Y byte came just before.
  function automatic void predict_address(input logic [7:0] b);
    if (b[6:5] == 2'b01) begin
      if (addr_phase == 2'd2) begin
        beam_x     = {b[4:0], beam_x[4:0]};
        addr_phase = 2'd3;
      end else begin
        beam_y     = {b[4:0], beam_y[4:0]};
        addr_phase = 2'd1;
      end
    end else if (b[6:5] == 2'b11) begin
      beam_y[4:0] = b[4:0];
      addr_phase  = 2'd2;
    end else begin
      // Low-X always completes the address.
      beam_x[4:0] = b[4:0];
      addr_phase  = 2'd0;
      text_x      = int'(beam_x);
      text_y      = int'(beam_y);
      if (draw_cont) begin
        push_cmd(CMD_DRAW, int'(beam_x), int'(beam_y), 0);
      end else begin
        draw_cont = 1'b1;
        push_cmd(CMD_MOVE, int'(beam_x), int'(beam_y), 0);
      end
    end
  endfunction

  function automatic void predict_normal(input logic [7:0] b);
    if (b >= 8'h20 && b <= 8'h7F) begin
      predict_address(b);
      return;
    end
    case (b)
      CH_NUL, CH_BEL, CH_CAN, CH_FS: ;
      CH_BS: text_x = clamp_int(text_x - int'(regs.space_step), TEXT_MIN, TEXT_MAX);
      CH_HT: text_x = clamp_int(text_x + int'(regs.space_step), TEXT_MIN, TEXT_MAX);
      CH_LF: text_y = clamp_int(text_y - int'(regs.line_step), TEXT_MIN, TEXT_MAX);
      CH_VT: text_y = clamp_int(text_y + int'(regs.line_step), TEXT_MIN, TEXT_MAX);
      CH_CR: begin
        text_y    = clamp_int(text_y - int'(regs.return_step), TEXT_MIN, TEXT_MAX);
        text_x    = 0;
        dots_on   = 1'b1;
        mode      = MODE_ALPHA;
        label_len = 0;
      end
      CH_US: begin
        mode      = MODE_ALPHA;
        label_len = 0;
      end
      CH_ESC: mode = MODE_ESC;
      CH_GS: draw_cont = 1'b0;
      CH_RS: begin
        mode   = MODE_INCR;
        step_x = 0;
        step_y = 0;
      end
      default: push_cmd(CMD_UNKNOWN, 0, 0, int'(b));
    endcase
  endfunction

  // The byte after ESC is always consumed.
  function automatic void predict_escape(input logic [7:0] b);
    mode = MODE_NORMAL;
    if (b == CH_FF) begin
      dots_on = 1'b1;
      beam_x  = '0;
      beam_y  = '0;
      push_cmd(CMD_ERASE, 0, 0, 0);
      push_cmd(CMD_FONT, 0, 0, 8);
      push_cmd(CMD_STYLE, 0, 0, 0);
    end else if (b >= "0" && b <= "3") begin
      push_cmd(CMD_FONT, 0, 0, 8 + 2 * int'(b[1:0]));
    end else if (b == "@") begin
      push_cmd(CMD_FILL, 0, 0, 1);
    end else if (b >= "A" && b <= "G") begin
      push_cmd(CMD_FILL, 0, 0, 32'h7FFF);
    end else if (b >= 8'h60 && b <= 8'h64) begin
      push_cmd(CMD_STYLE, 0, 0, int'(b[2:0]));
    end else if (b >= "x" && b <= "z") begin
      push_cmd(CMD_STYLE, 0, 0, 5 + int'(b[2:0]));
    end
  endfunction

  function automatic void predict_incremental(input logic [7:0] b);
    int dx;
    int dy;
    dx = 0;
    dy = 0;
    if (b == CH_US) begin
      // Leave the mode: move to the stepped beam, then open a text run.
      beam_x = 10'(clamp_int(int'(beam_x) + step_x, 0, COORD_MAX));
      beam_y = 10'(clamp_int(int'(beam_y) + step_y, 0, COORD_MAX));
      push_cmd(CMD_MOVE, int'(beam_x), int'(beam_y), 0);
      text_x = clamp_int(text_x + step_x, 0, TEXT_MAX);
      text_y = clamp_int(text_y + step_y, 0, TEXT_MAX);
      mode   = MODE_NORMAL;
      predict_normal(b);
      return;
    end
    case (b)
      " ": dots_on = 1'b0;
      "P": dots_on = 1'b1;
      "A": dx = 1;
      "E": begin dx = 1; dy = 1; end
      "D": dy = 1;
      "F": begin dx = -1; dy = 1; end
      "B": dx = -1;
      "J": begin dx = -1; dy = -1; end
      "H": dy = -1;
      "I": begin dx = 1; dy = -1; end
      default: ;
    endcase
    step_x = clamp_int(step_x + dx, -32768, 32767);
    step_y = clamp_int(step_y + dy, -32768, 32767);
  endfunction

  function automatic void predict_alpha(input logic [7:0] b);
    if (b >= 8'h20 && b <= 8'h7F) begin
      if (label_len == 0) push_cmd(CMD_MOVE, text_x, text_y, 0);
      push_cmd(CMD_TEXT_CHAR, text_x, text_y, int'(b));
      text_x = clamp_int(text_x + int'(regs.char_advance), TEXT_MIN, TEXT_MAX);
      if (label_len < 32'hFFFF) label_len++;
      return;
    end
    // Any other byte closes the run and is then decoded as usual.
    if (label_len > 0) begin
      push_cmd(CMD_TEXT_END, text_x, text_y, (label_len > 32'h7FFF) ? 32'h7FFF : label_len);
      draw_cont = 1'b0;
    end
    label_len = 0;
    mode      = MODE_NORMAL;
    predict_normal(b);
  endfunction

  // Work out every command one accepted byte causes and mark the final one.
  function automatic void decode_byte(input logic [7:0] b);
    int       before_cnt;
    decoded_t tail;
    before_cnt = pending_cmds.size();
    case (mode)
      MODE_ALPHA: predict_alpha(b);
      MODE_ESC:   predict_escape(b);
      MODE_INCR:  predict_incremental(b);
      default:    predict_normal(b);
    endcase
    if (pending_cmds.size() > before_cnt) begin
      tail      = pending_cmds[pending_cmds.size() - 1];
      tail.last = 1'b1;
      pending_cmds[pending_cmds.size() - 1] = tail;
    end
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] v);
    case (reg_idx_t'(idx))
      REG_CHAR_ADVANCE: regs.char_advance = v;
      REG_SPACE_STEP:   regs.space_step   = v;
      REG_LINE_STEP:    regs.line_step    = v;
      REG_RETURN_STEP:  regs.return_step  = v;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0d: %s", cycles, msg);
  endtask

  // Compare the accepted command against the oldest expectation.
  task automatic check_result();
    decoded_t want;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("command %0d arrived with nothing expected", res_ch.command));
    end else begin
      want = pending_cmds.pop_front();
      results_checked++;
      if (res_ch.command !== want.body.command)
        report_mismatch($sformatf("command %0d, expected %0d", res_ch.command,
                                  want.body.command));
      if (res_ch.pos_x !== want.body.pos_x)
        report_mismatch($sformatf("pos_x %0d, expected %0d", res_ch.pos_x, want.body.pos_x));
      if (res_ch.pos_y !== want.body.pos_y)
        report_mismatch($sformatf("pos_y %0d, expected %0d", res_ch.pos_y, want.body.pos_y));
      if (res_ch.argument !== want.body.argument)
        report_mismatch($sformatf("argument %0d, expected %0d", res_ch.argument,
                                  want.body.argument));
      if (res_ch.pen_down !== want.body.pen_down)
        report_mismatch($sformatf("pen_down %0b, expected %0b", res_ch.pen_down,
                                  want.body.pen_down));
      if (res_ch.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", res_ch.last, want.last));
    end
  endtask

  // Monitor: predict on accepted requests first, then check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (stream_ch.valid && stream_ch.ready) decode_byte(stream_ch.stream_byte);
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (res_ch.valid && res_ch.ready) check_result();
    end
  end

  // Watchdog on the run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d commands outstanding", cycles,
               pending_cmds.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle lengths are mostly short with the occasional long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) stall_left = idle_len();
    end
  end

  // Send one stream byte, with an optional gap before it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      stream_ch.stream_byte <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    do @(posedge clk); while (!(stream_ch.valid && stream_ch.ready));
    bytes_sent++;
  endtask

  // Drop the request line and let every expected command come out.
  task automatic wait_drained();
    @(negedge clk);
    stream_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_all_regs(input logic [7:0] ca, input logic [7:0] ss,
                                input logic [7:0] ls, input logic [7:0] rs);
    wait_drained();
    write_reg(REG_CHAR_ADVANCE, ca);
    write_reg(REG_SPACE_STEP, ss);
    write_reg(REG_LINE_STEP, ls);
    write_reg(REG_RETURN_STEP, rs);
  endtask

  // Address forms, including the lone low-X and high-Y followed by low-X.
  task automatic test_addressing();
    send_byte(8'h20); send_byte(8'h60); send_byte(8'h20); send_byte(8'h40);
    send_byte(8'h3F); send_byte(8'h7F); send_byte(8'h3F); send_byte(8'h5F);
    send_byte(8'h45);
    send_byte(8'h35); send_byte(8'h4A);
    send_byte(CH_GS); send_byte(8'h40);
  endtask

  // Every escape action plus the ignored codes.
  task automatic test_escape_codes();
    send_byte(CH_ESC); send_byte(CH_FF);
    send_byte(CH_ESC); send_byte("0");
    send_byte(CH_ESC); send_byte("3");
    send_byte(CH_ESC); send_byte("@");
    send_byte(CH_ESC); send_byte("A");
    send_byte(CH_ESC); send_byte("G");
    send_byte(CH_ESC); send_byte(8'h60);
    send_byte(CH_ESC); send_byte("d");
    send_byte(CH_ESC); send_byte("x");
    send_byte(CH_ESC); send_byte("z");
    send_byte(CH_ESC); send_byte("/"); send_byte(8'h55);
    send_byte(CH_ESC); send_byte("[");
    send_byte(CH_ESC); send_byte(8'hFF);
  endtask

  // Text runs opened by US and CR, closed by control bytes, and an empty run.
  task automatic test_text_runs();
    send_byte(CH_US); send_byte("A"); send_byte(8'h7F); send_byte(8'h20);
    send_byte(CH_CR); send_byte(" "); send_byte(CH_LF);
    send_byte(CH_CR); send_byte(CH_ESC); send_byte("1");
  endtask

  // Pen control, all eight directions, an ignored byte and the exit on US.
  task automatic test_incremental();
    send_byte(CH_RS);
    send_byte(" "); send_byte("A"); send_byte("E"); send_byte("D"); send_byte("F");
    send_byte("B"); send_byte("J"); send_byte("H"); send_byte("I"); send_byte("Q");
    send_byte(CH_US); send_byte("Z"); send_byte(8'h80);
    send_byte(CH_RS); send_byte("P"); send_byte("A"); send_byte(CH_US); send_byte(CH_NUL);
  endtask

  // Cursor codes, ignored codes and unknown bytes in normal mode.
  task automatic test_control_codes();
    send_byte(CH_BS); send_byte(CH_HT); send_byte(CH_LF); send_byte(CH_VT);
    send_byte(CH_NUL); send_byte(CH_BEL); send_byte(CH_CAN); send_byte(CH_FS);
    send_byte(CH_FF); send_byte(8'h01); send_byte(8'h80); send_byte(8'hFF);
    send_byte(CH_US); send_byte("q"); send_byte(CH_NUL);
  endtask

  // Push text x into its upper limit and text y into its lower limit.
  task automatic test_position_saturation();
    write_all_regs(8'd255, 8'd255, 8'd255, 8'd255);
    repeat (129) send_byte(CH_HT);
    repeat (129) send_byte(CH_LF);
    send_byte(CH_US); send_byte("M"); send_byte("N"); send_byte(CH_NUL);
    send_byte(CH_CR); send_byte("c"); send_byte(CH_NUL);
  endtask

  // Well-formed sequences with random content.
  task automatic send_address();
    case ($urandom_range(0, 5))
      0, 1: begin
        send_byte(8'h20 | 8'($urandom_range(0, 31)));
        send_byte(8'h60 | 8'($urandom_range(0, 31)));
        send_byte(8'h20 | 8'($urandom_range(0, 31)));
        send_byte(8'h40 | 8'($urandom_range(0, 31)));
      end
      2: begin
        send_byte(8'h60 | 8'($urandom_range(0, 31)));
        send_byte(8'h20 | 8'($urandom_range(0, 31)));
        send_byte(8'h40 | 8'($urandom_range(0, 31)));
      end
      3: begin
        send_byte(8'h20 | 8'($urandom_range(0, 31)));
        send_byte(8'h40 | 8'($urandom_range(0, 31)));
      end
      4: send_byte(8'h40 | 8'($urandom_range(0, 31)));
      default: begin
        send_byte(CH_GS);
        send_byte(8'h20 | 8'($urandom_range(0, 31)));
        send_byte(8'h20 | 8'($urandom_range(0, 31)));
        send_byte(8'h60 | 8'($urandom_range(0, 31)));
        send_byte(8'h40 | 8'($urandom_range(0, 31)));
      end
    endcase
  endtask

  task automatic send_text_run();
    int n;
    send_byte(($urandom_range(0, 1) == 0) ? CH_US : CH_CR);
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7F)));
    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(8'h80, 8'hFF)));
    else send_byte(8'($urandom_range(0, 31)));
  endtask

  task automatic send_escape();
    send_byte(CH_ESC);
    case ($urandom_range(0, 9))
      0: send_byte(CH_FF);
      1: send_byte(8'h30 + 8'($urandom_range(0, 3)));
      2: send_byte("@");
      3: send_byte(8'h41 + 8'($urandom_range(0, 6)));
      4: send_byte(8'h60 + 8'($urandom_range(0, 4)));
      5: send_byte(8'h78 + 8'($urandom_range(0, 2)));
      6: send_byte("/");
      7: send_byte("[");
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_incremental();
    int n;
    send_byte(CH_RS);
    n = $urandom_range(0, 12);
    repeat (n) begin
      case ($urandom_range(0, 11))
        0: send_byte(" ");
        1: send_byte("P");
        2: send_byte("A");
        3: send_byte("E");
        4: send_byte("D");
        5: send_byte("F");
        6: send_byte("B");
        7: send_byte("J");
        8: send_byte("H");
        9: send_byte("I");
        default: send_byte(8'($urandom_range(8'h20, 8'hFF)));
      endcase
    end
    send_byte(CH_US);
  endtask

  task automatic send_control();
    case ($urandom_range(0, 8))
      0: send_byte(CH_BS);
      1: send_byte(CH_HT);
      2: send_byte(CH_LF);
      3: send_byte(CH_VT);
      4: send_byte(CH_GS);
      5: send_byte(CH_NUL);
      6: send_byte(CH_FS);
      7: send_byte(8'($urandom_range(0, 31)));
      default: send_byte(8'($urandom_range(8'h80, 8'hFF)));
    endcase
  endtask

  // Mostly well-formed sequences, the rest random noise.
  task automatic test_random_traffic(input int n_items);
    int stop_at;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_address();
        3, 4:    send_text_run();
        5:       send_escape();
        6:       send_incremental();
        7:       send_control();
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Test sequence.
  initial begin
    stream_ch.valid       = 1'b0;
    stream_ch.stream_byte = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    res_ch.ready          = 1'b1;
    gap_pct               = 20;
    stall_pct             = 20;
    stall_left            = 0;
    reset_predictor();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_addressing();
    test_escape_codes();
    test_text_runs();
    test_incremental();
    test_control_codes();
    test_random_traffic(12);

    // Random register values with no idling on either side.
    write_all_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic(8);

    // All registers at zero under heavy idling.
    write_all_regs(8'd0, 8'd0, 8'd0, 8'd0);
    gap_pct   = 50;
    stall_pct = 50;
    test_random_traffic(8);

    // All registers at full scale; the long runs go without idling.
    gap_pct   = 0;
    stall_pct = 0;
    test_position_saturation();
    gap_pct   = 15;
    stall_pct = 30;
    test_random_traffic(4);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Summary: %0d stream bytes in, %0d commands checked, %0d register writes,",
             bytes_sent, results_checked, reg_writes);
    $display("  %0d mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
